### src/edfvd_pkg.sv
// Shared types and constants of the EDF-VD job scheduler.
package edfvd_pkg;

  // Job table geometry
  localparam int unsigned JOB_SLOTS = 64;
  localparam int unsigned SLOT_W    = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(JOB_SLOTS + 1);

  // Scaled deadline product: 32 bit deadline times Q1.16 factor of 17 bits
  localparam int unsigned SCALE_W = 17;
  localparam int unsigned PROD_W  = 32 + SCALE_W;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HYPER_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VD_SCALE     = 1'b1;
  localparam logic [SCALE_W-1:0]   VD_SCALE_ONE     = 17'h10000;

  // Input actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DECIDE = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_RUN      = 3'd0;
  localparam logic [2:0] KIND_IDLE     = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_ACCEPT   = 3'd3;
  localparam logic [2:0] KIND_REJECT   = 3'd4;

  typedef struct packed {
    logic        action;
    logic [31:0] arrival;
    logic [31:0] rel_deadline;
    logic [31:0] exec_time;
    logic        high_crit;
    logic [5:0]  task_id;
    logic [11:0] job_seq;
  } edfvd_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] slice_start;
    logic [31:0] slice_end;
    logic [5:0]  run_task;
    logic [11:0] run_job;
    logic        extends_previous;
  } edfvd_out_t;

  // One job table entry
  typedef struct packed {
    logic [31:0] arrival;
    logic [31:0] vdl;
    logic [31:0] remaining;
    logic [5:0]  task_id;
    logic [11:0] job_seq;
    logic        finished;
  } slot_t;

  // Job table access control
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
  } tbl_ctl_t;

endpackage

### src/edf_vd_job_scheduler_core.sv
// Top level of the EDF-VD job scheduler: sequencer, arithmetic and job table.
//
// One item is worked on at a time; in_stall_o is high from acceptance until
// the result has been loaded into the output register. An insert goes
// through accept, deadline multiply, table write and result load. A decision
// that runs a job walks the single read port of the job table one slot per
// cycle over the filled slots to find the earliest virtual deadline and the
// next arrival, folds in the last read and leaves the scan; then the slice end
// is picked, the remaining time is written back and the result is loaded. A
// decision that idles or finds the schedule complete scans and picks alike but
// writes nothing back. A rejected insert or a decision at or beyond the
// horizon goes from acceptance straight to the result load. A waiting result
// in the output register does not stop the next item being accepted; only its
// result load waits.
// The table is not cleared at reset: only slots below the fill count are read.
module edf_vd_job_scheduler_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  edfvd_pkg::edfvd_in_t               in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output edfvd_pkg::edfvd_out_t              out_data_o,
  input  logic                               cfg_we_i,
  input  logic [edfvd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                        cfg_wdata_i
);
  import edfvd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_INS, ST_SCAN, ST_PICK, ST_RUN, ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  edfvd_in_t         cmd_q, cmd_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0]  filled_q, filled_d;
  logic [31:0]       now_q, now_d;
  logic              last_vld_q, last_vld_d;
  logic [SLOT_W-1:0] last_slot_q, last_slot_d;
  logic [31:0]       hyper_q, hyper_d;
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              dv_q, dv_d;
  logic [SLOT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [31:0]       next_q, next_d;
  logic              best_vld_q, best_vld_d;
  logic [SLOT_W-1:0] best_idx_q, best_idx_d;
  slot_t             best_q, best_d;
  logic [32:0]       finish_q, finish_d;
  logic              take_next_q, take_next_d;
  edfvd_out_t        res_q, res_d;
  logic              out_vld_q, out_vld_d;
  edfvd_out_t        out_q, out_d;

  tbl_ctl_t          tbl_ctl;
  slot_t             tbl_wdata;
  slot_t             tbl_rdata;

  logic              in_acc;
  logic              tbl_full;
  logic [32:0]       scaled_dl;
  logic [33:0]       vdl_sum;
  logic [31:0]       vdl_sat;
  logic [32:0]       over_next;
  logic [31:0]       run_end;
  logic [31:0]       new_rem;

  edfvd_job_table u_table (
    .clk_i     (clk_i),
    .ctl_i     (tbl_ctl),
    .wr_data_i (tbl_wdata),
    .rd_data_o (tbl_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign tbl_full = (filled_q == CNT_W'(JOB_SLOTS));

  // virtual deadline: scaled or plain deadline plus arrival, saturating
  assign scaled_dl = cmd_q.high_crit ? prod_q[PROD_W-1:16] : {1'b0, cmd_q.rel_deadline};
  assign vdl_sum   = 34'(cmd_q.arrival) + 34'(scaled_dl);
  assign vdl_sat   = (vdl_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : vdl_sum[31:0];

  // slice end and remaining time after the run
  assign over_next = finish_q - {1'b0, next_q};
  assign run_end   = take_next_q ? next_q : finish_q[31:0];
  assign new_rem   = take_next_q ? over_next[31:0] : 32'd0;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    prod_d      = prod_q;
    filled_d    = filled_q;
    now_d       = now_q;
    last_vld_d  = last_vld_q;
    last_slot_d = last_slot_q;
    hyper_d     = hyper_q;
    scale_d     = scale_q;
    iss_d       = iss_q;
    dv_d        = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    next_d      = next_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    finish_d    = finish_q;
    take_next_d = take_next_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q && out_stall_i;
    out_d       = out_q;
    tbl_ctl     = '0;
    tbl_wdata   = best_q;

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HYPER_PERIOD: hyper_d = cfg_wdata_i;
        REG_VD_SCALE:     scale_d = cfg_wdata_i[SCALE_W-1:0];
        default:          ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d = in_data_i;
          res_d = '0;
          if (in_data_i.action == ACT_INSERT) begin
            res_d.run_task = in_data_i.task_id;
            res_d.run_job  = in_data_i.job_seq;
            if (tbl_full || in_data_i.arrival >= hyper_q) begin
              res_d.kind = KIND_REJECT;
              state_d    = ST_EMIT;
            end else begin
              state_d = ST_MUL;
            end
          end else if (now_q >= hyper_q) begin
            res_d.kind        = KIND_COMPLETE;
            res_d.slice_start = now_q;
            res_d.slice_end   = now_q;
            state_d           = ST_EMIT;
          end else begin
            iss_d      = '0;
            next_d     = hyper_q;
            best_vld_d = 1'b0;
            state_d    = ST_SCAN;
          end
        end
      end

      ST_MUL: begin
        prod_d  = PROD_W'(cmd_q.rel_deadline) * PROD_W'(scale_q);
        state_d = ST_INS;
      end

      ST_INS: begin
        tbl_ctl.wr_en       = 1'b1;
        tbl_ctl.wr_addr     = filled_q[SLOT_W-1:0];
        tbl_wdata.arrival   = cmd_q.arrival;
        tbl_wdata.vdl       = vdl_sat;
        tbl_wdata.remaining = cmd_q.exec_time;
        tbl_wdata.task_id   = cmd_q.task_id;
        tbl_wdata.job_seq   = cmd_q.job_seq;
        tbl_wdata.finished  = 1'b0;
        filled_d            = filled_q + 1'b1;
        res_d.kind          = KIND_ACCEPT;
        state_d             = ST_EMIT;
      end

      ST_SCAN: begin
        // issue one slot read per cycle
        if (iss_q < filled_q) begin
          tbl_ctl.rd_en   = 1'b1;
          tbl_ctl.rd_addr = iss_q[SLOT_W-1:0];
          dv_d            = 1'b1;
          cmp_idx_d       = iss_q[SLOT_W-1:0];
          iss_d           = iss_q + 1'b1;
        end else if (!dv_q) begin
          state_d = ST_PICK;
        end
        // fold the slot read last cycle into next arrival and best job
        if (dv_q && !tbl_rdata.finished) begin
          if (tbl_rdata.arrival > now_q) begin
            if (tbl_rdata.arrival < next_q) begin
              next_d = tbl_rdata.arrival;
            end
          end else if (tbl_rdata.remaining != 32'd0) begin
            if (!best_vld_q || tbl_rdata.vdl < best_q.vdl) begin
              best_vld_d = 1'b1;
              best_idx_d = cmp_idx_q;
              best_d     = tbl_rdata;
            end
          end
        end
      end

      ST_PICK: begin
        res_d.slice_start = now_q;
        if (best_vld_q) begin
          finish_d    = 33'(now_q) + 33'(best_q.remaining);
          take_next_d = (33'(next_q) < (33'(now_q) + 33'(best_q.remaining)));
          state_d     = ST_RUN;
        end else if (next_q > now_q && next_q < hyper_q) begin
          res_d.kind      = KIND_IDLE;
          res_d.slice_end = next_q;
          now_d           = next_q;
          state_d         = ST_EMIT;
        end else begin
          res_d.kind      = KIND_COMPLETE;
          res_d.slice_end = now_q;
          state_d         = ST_EMIT;
        end
      end

      ST_RUN: begin
        tbl_ctl.wr_en       = 1'b1;
        tbl_ctl.wr_addr     = best_idx_q;
        tbl_wdata.remaining = new_rem;
        tbl_wdata.finished  = (new_rem == 32'd0);
        res_d.kind          = KIND_RUN;
        res_d.slice_end     = run_end;
        res_d.run_task      = best_q.task_id;
        res_d.run_job       = best_q.job_seq;
        res_d.extends_previous = last_vld_q && (last_slot_q == best_idx_q);
        last_vld_d          = 1'b1;
        last_slot_d         = best_idx_q;
        now_d               = run_end;
        state_d             = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      filled_q    <= '0;
      now_q       <= '0;
      last_vld_q  <= 1'b0;
      last_slot_q <= '0;
      hyper_q     <= '0;
      scale_q     <= VD_SCALE_ONE;
      iss_q       <= '0;
      dv_q        <= 1'b0;
      best_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      now_q       <= now_d;
      last_vld_q  <= last_vld_d;
      last_slot_q <= last_slot_d;
      hyper_q     <= hyper_d;
      scale_q     <= scale_d;
      iss_q       <= iss_d;
      dv_q        <= dv_d;
      best_vld_q  <= best_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    prod_q      <= prod_d;
    cmp_idx_q   <= cmp_idx_d;
    next_q      <= next_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
    finish_q    <= finish_d;
    take_next_q <= take_next_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

endmodule

### src/edfvd_job_table.sv
// Job table memory: one write port, one registered read port.
module edfvd_job_table (
  input  logic                clk_i,
  input  edfvd_pkg::tbl_ctl_t ctl_i,
  input  edfvd_pkg::slot_t    wr_data_i,
  output edfvd_pkg::slot_t    rd_data_o
);
  import edfvd_pkg::*;

  slot_t mem [JOB_SLOTS];
  slot_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[ctl_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/edfvd_checker.sv
// Port-level checks of the EDF-VD job scheduler and their binding.
module edfvd_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input edfvd_pkg::edfvd_out_t out_data_o
);
  import edfvd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted in back-to-back cycles");

  // insert results carry no times and no merge flag
  a_insert_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_ACCEPT || out_data_o.kind == KIND_REJECT)
    |-> out_data_o.slice_start == 32'd0 && out_data_o.slice_end == 32'd0
        && !out_data_o.extends_previous)
    else $error("insert result with slice fields set");

  // run slices and idle jumps always move time forward
  a_time_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_RUN || out_data_o.kind == KIND_IDLE)
    |-> out_data_o.slice_end > out_data_o.slice_start)
    else $error("slice does not advance time");

  // completion reports an empty slice
  a_complete_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_COMPLETE
    |-> out_data_o.slice_end == out_data_o.slice_start && !out_data_o.extends_previous)
    else $error("completion with non-empty slice");

endmodule

bind edf_vd_job_scheduler_core edfvd_checker u_edfvd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/testbench.sv
// Testbench of the EDF-VD job scheduler core: directed and random items, built-in scheduler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import edfvd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_REPORTS    = 10;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  edfvd_in_t            in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  edfvd_out_t           out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = REG_HYPER_PERIOD;
  logic [31:0]          cfg_wdata = '0;

  edf_vd_job_scheduler_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler state as the testbench sees it
  logic [31:0]        horizon   = '0;
  logic [SCALE_W-1:0] vd_factor = VD_SCALE_ONE;
  logic [31:0]        job_arrival [JOB_SLOTS];
  logic [31:0]        job_vdl     [JOB_SLOTS];
  logic [31:0]        job_left    [JOB_SLOTS];
  logic [5:0]         job_task    [JOB_SLOTS];
  logic [11:0]        job_seq_no  [JOB_SLOTS];
  logic               job_done    [JOB_SLOTS];
  int unsigned        jobs_filled   = 0;
  logic [31:0]        sched_now     = '0;
  int                 prev_run_slot = -1;

  edfvd_out_t expected_results [$];
  edfvd_out_t last_prediction;
  edfvd_out_t result_want;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int quiet_cycles    = 0;
  int kinds_seen [5]  = '{default: 0};

  // Next result of the scheduler for one item; updates the table, time and last slot
  function automatic edfvd_out_t predict_schedule(input edfvd_in_t it);
    edfvd_out_t  r;
    logic [63:0] dl;
    logic [63:0] vdl;
    logic [63:0] done_at;
    logic [31:0] t_now;
    logic [31:0] next_arr;
    logic [31:0] stop;
    int          best;
    int          i;
    r = '0;
    if (it.action == ACT_INSERT) begin
      r.run_task = it.task_id;
      r.run_job  = it.job_seq;
      if (jobs_filled >= JOB_SLOTS || it.arrival >= horizon) begin
        r.kind = KIND_REJECT;
        return r;
      end
      dl = {32'b0, it.rel_deadline};
      if (it.high_crit) begin
        dl = (dl * {47'b0, vd_factor}) >> 16;
      end
      vdl = {32'b0, it.arrival} + dl;
      if (vdl > 64'hFFFF_FFFF) vdl = 64'hFFFF_FFFF;
      job_arrival[jobs_filled] = it.arrival;
      job_vdl[jobs_filled]     = vdl[31:0];
      job_left[jobs_filled]    = it.exec_time;
      job_task[jobs_filled]    = it.task_id;
      job_seq_no[jobs_filled]  = it.job_seq;
      job_done[jobs_filled]    = 1'b0;
      jobs_filled++;
      r.kind = KIND_ACCEPT;
      return r;
    end

    t_now = sched_now;
    r.slice_start = t_now;
    r.slice_end   = t_now;
    if (t_now >= horizon) begin
      r.kind = KIND_COMPLETE;
      return r;
    end
    // earliest virtual deadline among active jobs, and the next release
    next_arr = horizon;
    best     = -1;
    for (i = 0; i < int'(jobs_filled); i++) begin
      if (!job_done[i]) begin
        if (job_arrival[i] > t_now) begin
          if (job_arrival[i] < next_arr) next_arr = job_arrival[i];
        end else if (job_left[i] != 0) begin
          if (best < 0 || job_vdl[i] < job_vdl[best]) best = i;
        end
      end
    end
    if (best < 0) begin
      if (next_arr > t_now && next_arr < horizon) begin
        r.kind      = KIND_IDLE;
        r.slice_end = next_arr;
        sched_now   = next_arr;
      end else begin
        r.kind = KIND_COMPLETE;
      end
      return r;
    end
    // run until the next release, the horizon or completion
    done_at = {32'b0, t_now} + {32'b0, job_left[best]};
    stop    = ({32'b0, next_arr} < done_at) ? next_arr : done_at[31:0];
    job_left[best] = job_left[best] - (stop - t_now);
    if (job_left[best] == 0) job_done[best] = 1'b1;
    r.kind             = KIND_RUN;
    r.slice_end        = stop;
    r.run_task         = job_task[best];
    r.run_job          = job_seq_no[best];
    r.extends_previous = (best == prev_run_slot);
    prev_run_slot      = best;
    sched_now          = stop;
    return r;
  endfunction

  function automatic edfvd_in_t make_insert(input logic [31:0] arr, input logic [31:0] rel,
                                            input logic [31:0] exec, input logic high,
                                            input logic [5:0] tid, input logic [11:0] seq);
    edfvd_in_t it;
    it.action       = ACT_INSERT;
    it.arrival      = arr;
    it.rel_deadline = rel;
    it.exec_time    = exec;
    it.high_crit    = high;
    it.task_id      = tid;
    it.job_seq      = seq;
    return it;
  endfunction

  function automatic edfvd_in_t random_fields();
    edfvd_in_t it;
    it.action       = ACT_DECIDE;
    it.arrival      = $urandom;
    it.rel_deadline = $urandom;
    it.exec_time    = $urandom;
    it.high_crit    = 1'($urandom_range(0, 1));
    it.task_id      = 6'($urandom_range(0, 63));
    it.job_seq      = 12'($urandom_range(0, 4095));
    return it;
  endfunction

  // Decisions carry random junk in the insert-only fields
  function automatic edfvd_in_t decide_item();
    return random_fields();
  endfunction

  // Insert that cannot be taken: at or beyond the horizon, or anything once the table is full
  function automatic edfvd_in_t random_reject();
    edfvd_in_t it;
    it        = random_fields();
    it.action = ACT_INSERT;
    if (jobs_filled < JOB_SLOTS) it.arrival = $urandom_range(horizon, 32'hFFFF_FFFF);
    return it;
  endfunction

  // Job released mostly just ahead of the current time, sometimes far ahead or in the past
  function automatic edfvd_in_t random_job();
    edfvd_in_t   it;
    logic [31:0] room;
    int          pick;
    it        = random_fields();
    it.action = ACT_INSERT;
    pick      = $urandom_range(0, 99);
    if (sched_now >= horizon) begin
      it.arrival = $urandom_range(0, horizon - 1);
    end else begin
      room = horizon - 1 - sched_now;
      if (pick < 70) it.arrival = sched_now + $urandom_range(0, (room < 400) ? room : 400);
      else if (pick < 85) it.arrival = sched_now + $urandom_range(0, room);
      else it.arrival = $urandom_range(0, sched_now);
    end
    it.rel_deadline = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2000);
    pick = $urandom_range(0, 99);
    if (pick < 5) it.exec_time = '0;
    else if (pick < 8) it.exec_time = $urandom_range(1000, 50000);
    else it.exec_time = $urandom_range(1, 300);
    return it;
  endfunction

  // Offer one item, with random gaps, and log its expected result once taken
  task automatic send_item(input edfvd_in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    last_prediction = predict_schedule(it);
    expected_results.push_back(last_prediction);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Both registers, one per cycle; only while the block is idle
  task automatic set_regs(input logic [31:0] hp, input logic [31:0] scale);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_HYPER_PERIOD;
    cfg_wdata <= hp;
    @(posedge clk);
    cfg_idx   <= REG_VD_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_we    <= 1'b0;
    horizon   = hp;
    vd_factor = scale[SCALE_W-1:0];
  endtask

  // Reset configuration: horizon of zero, so nothing is taken and the schedule is over
  task automatic test_reset_defaults();
    send_item(decide_item());
    send_item(make_insert(32'd0, 32'd5, 32'd5, 1'b0, 6'd7, 12'd7));
  endtask

  // Arrival at the horizon, zero and oversized scale factors, deadline saturation
  task automatic test_deadline_saturation();
    wait_drained();
    set_regs(32'hFFFF_FFFF, 32'd0);
    send_item(make_insert(32'hFFFF_FFFF, 32'd1, 32'd1, 1'b0, 6'd0, 12'd0));
    send_item(make_insert(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 6'd63, 12'd4095));
    wait_drained();
    // upper write bits fall away: factor becomes 0x1FFFF
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(make_insert(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd5, 1'b1, 6'd42, 12'd2730));
  endtask

  // Deadline tie, preemption at a release, zero-length job, idle jumps, end at the horizon
  task automatic test_edf_order();
    wait_drained();
    set_regs(32'd1000, 32'(VD_SCALE_ONE));
    send_item(make_insert(32'd0, 32'd100, 32'd30, 1'b1, 6'd1, 12'd1));
    send_item(make_insert(32'd0, 32'd100, 32'd20, 1'b0, 6'd2, 12'd2));
    send_item(make_insert(32'd10, 32'd5, 32'd0, 1'b0, 6'd3, 12'd3));
    send_item(make_insert(32'd50, 32'd10, 32'd15, 1'b0, 6'd0, 12'd0));
    repeat (6) send_item(decide_item());
    send_item(make_insert(32'd500, 32'd40, 32'd3, 1'b1, 6'd4, 12'd4));
    repeat (3) send_item(decide_item());
    send_item(make_insert(32'd900, 32'd0, 32'd1000, 1'b0, 6'd5, 12'd5));
    repeat (3) send_item(decide_item());
  endtask

  // Bursts of jobs among decisions and refused inserts, over a fresh horizon
  task automatic test_random_mix(input int sender_pct, input int stall_pct,
                                 input int budget, input int n_items);
    int k;
    int burst;
    bit paused;
    wait_drained();
    set_regs(sched_now + $urandom_range(3000, 12000), $urandom_range(0, VD_SCALE_ONE));
    send_idle_pct  = sender_pct;
    recv_stall_pct = stall_pct;
    k      = 0;
    paused = 1'b0;
    while (k < n_items) begin
      // hold off half way until the block has answered everything
      if (!paused && k >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if (budget > 0 && $urandom_range(1, 2 * (n_items - k)) <= budget) begin
        burst = $urandom_range(1, 3);
        repeat (burst) begin
          send_item(random_job());
          budget--;
          k++;
        end
      end else if ($urandom_range(0, 99) < 8) begin
        send_item(random_reject());
        k++;
      end else begin
        send_item(decide_item());
        k++;
      end
    end
  endtask

  // Fill whatever slots are left, then one insert more
  task automatic test_table_full();
    wait_drained();
    set_regs(32'hFFFF_FFFF, 32'(VD_SCALE_ONE));
    while (jobs_filled < JOB_SLOTS) begin
      send_item(make_insert(sched_now + $urandom_range(0, 50), $urandom_range(0, 500),
                            $urandom_range(1, 20), 1'($urandom_range(0, 1)),
                            6'($urandom_range(0, 63)), 12'($urandom_range(0, 4095))));
    end
    send_item(make_insert(sched_now, 32'd10, 32'd10, 1'b0, 6'd5, 12'd5));
  endtask

  // Decide until a decision reports the schedule complete, then once more
  task automatic test_run_to_horizon();
    int n;
    n = 0;
    do begin
      send_item(decide_item());
      n++;
    end while (last_prediction.kind != KIND_COMPLETE && n < 1000);
    send_item(decide_item());
  endtask

  // Result side: random stall, compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (out_data.kind <= KIND_REJECT) kinds_seen[out_data.kind]++;
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected result: kind %0d start %h end %h task %0d job %0d ext %0d",
                   out_data.kind, out_data.slice_start, out_data.slice_end,
                   out_data.run_task, out_data.run_job, out_data.extends_previous);
        end
        mismatches++;
      end else begin
        result_want = expected_results.pop_front();
        if (out_data.kind != result_want.kind ||
            out_data.slice_start != result_want.slice_start ||
            out_data.slice_end != result_want.slice_end ||
            out_data.run_task != result_want.run_task ||
            out_data.run_job != result_want.run_job ||
            out_data.extends_previous != result_want.extends_previous) begin
          if (mismatches < MAX_REPORTS) begin
            $display("result %0d expected: kind %0d start %h end %h task %0d job %0d ext %0d",
                     results_checked, result_want.kind, result_want.slice_start,
                     result_want.slice_end, result_want.run_task, result_want.run_job,
                     result_want.extends_previous);
            $display("result %0d actual:   kind %0d start %h end %h task %0d job %0d ext %0d",
                     results_checked, out_data.kind, out_data.slice_start,
                     out_data.slice_end, out_data.run_task, out_data.run_job,
                     out_data.extends_previous);
          end
          mismatches++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_deadline_saturation();
    test_edf_order();
    test_random_mix(34, 71, 18, 600);
    test_random_mix(71, 34, 18, 600);
    test_random_mix(0, 0, JOB_SLOTS, 600);
    test_table_full();
    test_run_to_horizon();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_results.size();
    $display("covered %0d items: %0d jobs taken, %0d inserts refused, %0d results checked",
             items_sent, kinds_seen[KIND_ACCEPT], kinds_seen[KIND_REJECT], results_checked);
    $display("decisions: %0d run slices, %0d idle jumps, %0d end-of-schedule answers",
             kinds_seen[KIND_RUN], kinds_seen[KIND_IDLE], kinds_seen[KIND_COMPLETE]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
